>>> hdl/tgcr_pkg.sv
// ----------------------------------------------------------------------------
// tgcr_pkg: shared types, constants and font table for the text console
// glyph renderer.
// Holds the register map, the control character codes, the cursor memory
// layout and the 8x8 bitmap font.
// ----------------------------------------------------------------------------
package tgcr_pkg;

	// Glyph cell geometry.
	localparam int CELL_SIZE = 8;
	localparam int CELL_PIXELS = CELL_SIZE * CELL_SIZE;
	localparam int PIX_IDX_W = $clog2(CELL_PIXELS);
	localparam int CELL_IDX_W = $clog2(CELL_SIZE);

	// Control character codes.
	localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
	localparam logic [7:0] CHAR_CR = 8'h0D;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PITCH_WORDS = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PIXEL_COLOR = 2'd3;

	// Register reset values.
	localparam logic [15:0] RST_SCREEN_WIDTH = 16'd1080;
	localparam logic [15:0] RST_SCREEN_HEIGHT = 16'd1920;
	localparam logic [15:0] RST_PITCH_WORDS = 16'd1080;
	localparam logic [31:0] RST_PIXEL_COLOR = 32'hFFFF_FFFF;

	// Cursor memory layout: one entry for the column, one for the row.
	localparam int CUR_ENTRIES = 2;
	localparam int CUR_AW = $clog2(CUR_ENTRIES);
	localparam logic [CUR_AW-1:0] CUR_ADDR_COL = 1'b0;
	localparam logic [CUR_AW-1:0] CUR_ADDR_ROW = 1'b1;

	typedef logic [15:0] coord_t;
	typedef logic [63:0] glyph_t;

	// Font bitmap of one character. Glyph line 0 sits in bits 63:56 and the
	// leftmost pixel of a line is the most significant bit of its byte.
	// Codes without a font entry, including every code of 128 and above,
	// are blank.
	function automatic glyph_t font_glyph(input logic [7:0] code);
		glyph_t g;
		case (code)
			8'h30: g = 64'h3C42464A_5262423C; // 0
			8'h31: g = 64'h18280808_0808083E; // 1
			8'h32: g = 64'h3C420204_1820407E; // 2
			8'h33: g = 64'h3C42021C_0202423C; // 3
			8'h34: g = 64'h040C1424_447E0404; // 4
			8'h35: g = 64'h7E40407C_0202027C; // 5
			8'h36: g = 64'h3C40407C_4242423C; // 6
			8'h37: g = 64'h7E020408_10101010; // 7
			8'h38: g = 64'h3C42423C_4242423C; // 8
			8'h39: g = 64'h3C42423E_0202023C; // 9
			8'h41: g = 64'h18244242_7E424242; // A
			8'h42: g = 64'h7C42427C_4242427C; // B
			8'h43: g = 64'h3C424040_4040423C; // C
			8'h44: g = 64'h78444242_42424478; // D
			8'h45: g = 64'h7E40407C_4040407E; // E
			8'h46: g = 64'h7E40407C_40404040; // F
			8'h47: g = 64'h3C42404E_4242423C; // G
			8'h48: g = 64'h4242427E_42424242; // H
			8'h49: g = 64'h7C101010_1010107C; // I
			8'h4A: g = 64'h1E040404_04044438; // J
			8'h4B: g = 64'h42444870_48444242; // K
			8'h4C: g = 64'h40404040_4040407E; // L
			8'h4D: g = 64'h42665A42_42424242; // M
			8'h4E: g = 64'h4262524A_46424242; // N
			8'h4F: g = 64'h3C424242_4242423C; // O
			8'h50: g = 64'h7C42427C_40404040; // P
			8'h51: g = 64'h3C424242_4A46423C; // Q
			8'h52: g = 64'h7C42427C_48444242; // R
			8'h53: g = 64'h3E40403C_0202027C; // S
			8'h54: g = 64'h7E101010_10101010; // T
			8'h55: g = 64'h42424242_4242423C; // U
			8'h56: g = 64'h42424242_42422418; // V
			8'h57: g = 64'h42424242_425A6642; // W
			8'h58: g = 64'h42422418_18244242; // X
			8'h59: g = 64'h42424224_18101010; // Y
			8'h5A: g = 64'h7E020408_1020407E; // Z
			default: g = '0;
		endcase
		return g;
	endfunction

endpackage

>>> hdl/tgcr_ram.sv
// ----------------------------------------------------------------------------
// tgcr_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle; the read data is registered, so it
// appears in the cycle after the address. Contents are undefined until written.
// ----------------------------------------------------------------------------
module tgcr_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

>>> hdl/text_glyph_console_renderer_core.sv
// ----------------------------------------------------------------------------
// text_glyph_console_renderer_core: 8x8 bitmap font text console renderer
// Turns character bytes into framebuffer pixel writes and keeps the text
// cursor in a small synchronous memory.
// ----------------------------------------------------------------------------
// Usage:
// Characters enter on in_valid/in_stall with char_code; a transaction takes
// place when in_valid is high and in_stall is low. Each printable character
// produces one pixel-write transaction on out_valid/out_stall per lit,
// on-screen glyph pixel, with last_pixel set on the final one. Newline and
// carriage return only move the cursor and produce no output.
// Configuration is written through cfg_we/cfg_index/cfg_data while idle.
// Sequence: an item reads the cursor (two memory reads), builds the clipped
// pixel mask and writes the cursor back (two memory writes). The glyph scan
// then walks the 64 cell positions one per cycle and ends right after the
// last lit pixel. A stalled output register holds its pixel and the scan
// waits at the next lit position. Reset restores the register defaults and
// puts the cursor at column 0, row 0; no clearing pass is needed.
// ----------------------------------------------------------------------------
module text_glyph_console_renderer_core
	import tgcr_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	// Input channel
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [7:0]           char_code,
	// Output channel
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [15:0]          pixel_x,
	output logic [15:0]          pixel_y,
	output logic [31:0]          word_offset,
	output logic [31:0]          color_value,
	output logic                 last_pixel,
	// Configuration port
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]          cfg_data
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_RD_COL,
		S_RD_ROW,
		S_PREP,
		S_WR_COL,
		S_WR_ROW,
		S_SCAN
	} state_t;

	state_t state_q;

	// Configuration registers.
	coord_t width_q;
	coord_t height_q;
	coord_t pitch_q;
	logic [31:0] color_q;

	// Item registers.
	logic [7:0] code_q;
	coord_t col_q;
	coord_t row_q;
	coord_t col_nxt_q;
	coord_t row_nxt_q;
	logic [CELL_PIXELS-1:0] mask_q;
	logic [PIX_IDX_W-1:0] idx_q;

	// Cursor memory signals.
	logic [CUR_ENTRIES-1:0] cur_vld_q;
	logic rd_vld_q;
	logic ram_we;
	logic [CUR_AW-1:0] ram_waddr;
	coord_t ram_wdata;
	logic [CUR_AW-1:0] ram_raddr;
	coord_t ram_rdata;
	coord_t rd_val;

	// Output register.
	logic out_valid_q;
	coord_t pix_x_q;
	coord_t pix_y_q;
	logic [31:0] offset_q;
	logic [31:0] color_out_q;
	logic last_q;

	// Preparation results.
	logic [CELL_PIXELS-1:0] mask_new;
	coord_t col_new;
	coord_t row_new;

	// Scan signals.
	logic [CELL_IDX_W-1:0] scan_line;
	logic [CELL_IDX_W-1:0] scan_bit;
	coord_t scan_x;
	coord_t scan_y;
	logic [31:0] scan_offset;
	logic out_free;
	logic emit;
	logic [CELL_PIXELS-1:0] mask_clr;
	logic scan_last;

	logic in_accept;

	assign in_stall = (state_q != S_IDLE);
	assign in_accept = in_valid && !in_stall;

	// Configuration register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= RST_SCREEN_WIDTH;
			height_q <= RST_SCREEN_HEIGHT;
			pitch_q <= RST_PITCH_WORDS;
			color_q <= RST_PIXEL_COLOR;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SCREEN_WIDTH: width_q <= cfg_data[15:0];
				REG_SCREEN_HEIGHT: height_q <= cfg_data[15:0];
				REG_PITCH_WORDS: pitch_q <= cfg_data[15:0];
				REG_PIXEL_COLOR: color_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Cursor memory: entry 0 holds the column, entry 1 the row.
	tgcr_ram #(
		.WIDTH(16),
		.DEPTH(CUR_ENTRIES)
	) u_cursor_ram (
		.clk(clk),
		.we(ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// The column is read on acceptance, the row in the following cycle.
	assign ram_raddr = (state_q == S_RD_COL) ? CUR_ADDR_ROW : CUR_ADDR_COL;
	assign ram_we = (state_q == S_WR_COL) || (state_q == S_WR_ROW);
	assign ram_waddr = (state_q == S_WR_ROW) ? CUR_ADDR_ROW : CUR_ADDR_COL;
	assign ram_wdata = (state_q == S_WR_ROW) ? row_nxt_q : col_nxt_q;

	// An entry never written since reset reads as zero.
	assign rd_val = rd_vld_q ? ram_rdata : '0;

	// Clipped pixel mask and next cursor position.
	always_comb begin
		glyph_t g;
		logic [CELL_SIZE-1:0] col_ok;
		logic [CELL_SIZE-1:0] row_ok;
		logic [16:0] adv;
		logic [16:0] down;
		g = font_glyph(code_q);
		for (int i = 0; i < CELL_SIZE; i++) begin
			col_ok[i] = (({1'b0, col_q} + 17'(i)) < {1'b0, width_q});
			row_ok[i] = (({1'b0, row_q} + 17'(i)) < {1'b0, height_q});
		end
		for (int l = 0; l < CELL_SIZE; l++) begin
			for (int b = 0; b < CELL_SIZE; b++) begin
				mask_new[l*CELL_SIZE+b] = g[CELL_PIXELS-1-(l*CELL_SIZE+b)]
					& col_ok[b] & row_ok[l];
			end
		end
		adv = {1'b0, col_q} + 17'(CELL_SIZE);
		down = {1'b0, row_q} + 17'(CELL_SIZE);
		col_new = adv[15:0];
		row_new = row_q;
		if (code_q == CHAR_NEWLINE) begin
			mask_new = '0;
			col_new = '0;
			row_new = ((down + 17'(CELL_SIZE)) > {1'b0, height_q}) ? '0 : down[15:0];
		end else if (code_q == CHAR_CR) begin
			mask_new = '0;
			col_new = '0;
		end else if ((adv + 17'(CELL_SIZE)) > {1'b0, width_q}) begin
			// Auto-wrap: the row saturates instead of wrapping.
			col_new = '0;
			row_new = down[16] ? 16'hFFFF : down[15:0];
		end
	end

	// Pixel at the current scan position.
	assign scan_line = idx_q[PIX_IDX_W-1:CELL_IDX_W];
	assign scan_bit = idx_q[CELL_IDX_W-1:0];
	assign scan_x = col_q + 16'(scan_bit);
	assign scan_y = row_q + 16'(scan_line);
	assign scan_offset = ({16'b0, scan_y} * {16'b0, pitch_q}) + {16'b0, scan_x};

	assign out_free = !out_valid_q || !out_stall;
	assign emit = (state_q == S_SCAN) && mask_q[idx_q] && out_free;
	assign mask_clr = mask_q & ~(CELL_PIXELS'(1) << idx_q);
	assign scan_last = (mask_clr == '0);

	// Sequencer, cursor bookkeeping and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			code_q <= '0;
			col_q <= '0;
			row_q <= '0;
			col_nxt_q <= '0;
			row_nxt_q <= '0;
			mask_q <= '0;
			idx_q <= '0;
			cur_vld_q <= '0;
			rd_vld_q <= 1'b0;
			out_valid_q <= 1'b0;
			pix_x_q <= '0;
			pix_y_q <= '0;
			offset_q <= '0;
			color_out_q <= '0;
			last_q <= 1'b0;
		end else begin
			rd_vld_q <= cur_vld_q[ram_raddr];

			// A new pixel fills the output register; a taken transaction frees it.
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (in_accept) begin
						code_q <= char_code;
						state_q <= S_RD_COL;
					end
				end
				S_RD_COL: begin
					col_q <= rd_val;
					state_q <= S_RD_ROW;
				end
				S_RD_ROW: begin
					row_q <= rd_val;
					state_q <= S_PREP;
				end
				S_PREP: begin
					mask_q <= mask_new;
					col_nxt_q <= col_new;
					row_nxt_q <= row_new;
					idx_q <= '0;
					state_q <= S_WR_COL;
				end
				S_WR_COL: begin
					cur_vld_q[CUR_ADDR_COL] <= 1'b1;
					state_q <= S_WR_ROW;
				end
				S_WR_ROW: begin
					cur_vld_q[CUR_ADDR_ROW] <= 1'b1;
					state_q <= (mask_q == '0) ? S_IDLE : S_SCAN;
				end
				S_SCAN: begin
					if (!mask_q[idx_q]) begin
						idx_q <= idx_q + PIX_IDX_W'(1);
					end else if (out_free) begin
						pix_x_q <= scan_x;
						pix_y_q <= scan_y;
						offset_q <= scan_offset;
						color_out_q <= color_q;
						last_q <= scan_last;
						mask_q <= mask_clr;
						idx_q <= idx_q + PIX_IDX_W'(1);
						if (scan_last) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign pixel_x = pix_x_q;
	assign pixel_y = pix_y_q;
	assign word_offset = offset_q;
	assign color_value = color_out_q;
	assign last_pixel = last_q;

	// No pixels are pending while the block waits for a character.
	a_idle_mask_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> (mask_q == '0))
		else $error("pixel mask not empty in idle");

	// The scan only runs while lit pixels remain.
	a_scan_has_work: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> (mask_q != '0))
		else $error("scan running with empty mask");

	// Every emitted pixel retires exactly one mask bit.
	a_emit_clears_one: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> ($countones(mask_q) == ($countones($past(mask_q)) - 1)))
		else $error("emit did not clear exactly one mask bit");

	// The final pixel of a character ends the item.
	a_last_ends_item: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && scan_last) |=> (state_q == S_IDLE && last_pixel && out_valid))
		else $error("last pixel did not end the item");

endmodule
